// ----- hdl/polyline_light_spreader_core_macros.svh -----
// Assertion macros shared by the polyline light spreader RTL.
`ifndef POLYLINE_LIGHT_SPREADER_CORE_MACROS_SVH
`define POLYLINE_LIGHT_SPREADER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PLS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pls assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pls assertion failed");

`endif

// ----- hdl/pls_pkg.sv -----
// Types and constants shared by the polyline light spreader modules.
package pls_pkg;

   localparam int COORD_W      = 16;  // signed Q8.8 coordinates
   localparam int LIDX_W       = 6;   // running light index
   localparam int NL_W         = 7;   // num_lights register
   localparam int SEG_W        = 11;  // segment_count register and accumulator
   localparam int SUM_W        = 12;  // accumulator plus budget, also n and n + 1
   localparam int DIVR_W       = 12;  // divisor and remainder of the shared divider
   localparam int DIVD_W       = (COORD_W > SUM_W) ? COORD_W : SUM_W;
   localparam int DIV_CNT_W    = $clog2(DIVD_W + 1);
   localparam int EMIT_W       = 7;   // lights per segment, up to RESULT_LIMIT
   localparam int RESULT_LIMIT = 64;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LIGHTS    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = CSR_IDX_W'(1);

   localparam logic [NL_W-1:0]  NUM_LIGHTS_RESET = NL_W'(50);
   localparam logic [SEG_W-1:0] SEG_COUNT_RESET  = SEG_W'(64);

   typedef struct packed {
      logic                       bolt_start;
      logic signed [COORD_W-1:0]  start_x;
      logic signed [COORD_W-1:0]  start_y;
      logic signed [COORD_W-1:0]  start_z;
      logic signed [COORD_W-1:0]  end_x;
      logic signed [COORD_W-1:0]  end_y;
      logic signed [COORD_W-1:0]  end_z;
   } pls_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  light_x;
      logic signed [COORD_W-1:0]  light_y;
      logic signed [COORD_W-1:0]  light_z;
      logic        [LIDX_W-1:0]   light_index;
      logic                       last_of_segment;
   } pls_rsp_type;

   // Control from the sequencer to one axis stepper.
   typedef struct packed {
      logic load_seg;   // capture start point and delta of a new segment
      logic load_div;   // capture quotient and remainder of |delta| / (n + 1)
      logic advance;    // move to the next light
   } pls_axis_ctl_type;

endpackage

// ----- hdl/pls_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
module pls_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pls_pkg::DIVD_W-1:0]  dividend,
   input  logic [pls_pkg::DIVR_W-1:0]  divisor,
   output logic                        done,
   output logic [pls_pkg::DIVD_W-1:0]  quotient,
   output logic [pls_pkg::DIVR_W-1:0]  remainder
);
   import pls_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0]     quo_ff, quo_in;
   logic [DIVR_W-1:0]     rem_ff, rem_in;
   logic [DIVR_W-1:0]     dvs_ff, dvs_in;
   logic [DIVR_W:0]       shifted;
   logic [DIVR_W:0]       diff;
   logic                  fits;

   // The partial remainder stays below the divisor, so the shifted value is
   // below twice the divisor and one subtraction restores it.
   assign shifted = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         rem_in = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hdl/pls_axis.sv -----
// One axis of the light placer: delta magnitude and a Bresenham-style stepper.
module pls_axis (
   input  logic                               clock,
   input  pls_pkg::pls_axis_ctl_type          ctl,
   input  logic signed [pls_pkg::COORD_W-1:0] start_coord,
   input  logic signed [pls_pkg::COORD_W-1:0] end_coord,
   input  logic        [pls_pkg::COORD_W-1:0] quo,
   input  logic        [pls_pkg::DIVR_W-1:0]  rem,
   input  logic        [pls_pkg::DIVR_W-1:0]  n1,
   output logic        [pls_pkg::COORD_W-1:0] mag,
   output logic signed [pls_pkg::COORD_W-1:0] pos
);
   import pls_pkg::*;

   logic [COORD_W-1:0]  a_ff, a_in;
   logic                neg_ff, neg_in;
   logic [COORD_W-1:0]  mag_ff, mag_in;
   logic [COORD_W-1:0]  qs_ff, qs_in;    // per-light quotient step
   logic [DIVR_W-1:0]   rs_ff, rs_in;    // per-light remainder step
   logic [COORD_W-1:0]  q_ff, q_in;     // |delta| * k / (n + 1), truncated
   logic [DIVR_W-1:0]   r_ff, r_in;     // matching remainder
   logic [COORD_W:0]    delta;
   logic [COORD_W:0]    delta_abs;
   logic [DIVR_W:0]     r_sum;
   logic [DIVR_W:0]     r_wrap;
   logic                wrap;
   logic [COORD_W:0]    offset;
   logic [COORD_W:0]    place;

   // The magnitude of a COORD_W+1 bit difference always fits COORD_W bits.
   assign delta     = {end_coord[COORD_W-1], end_coord}
                      - {start_coord[COORD_W-1], start_coord};
   assign delta_abs = delta[COORD_W] ? (~delta + 1'b1) : delta;

   assign r_sum  = {1'b0, r_ff} + {1'b0, rs_ff};
   assign r_wrap = r_sum - {1'b0, n1};
   assign wrap   = r_sum >= {1'b0, n1};

   // Truncation toward zero works on the magnitude; the sign goes on after.
   assign offset = neg_ff ? (~{1'b0, q_ff} + 1'b1) : {1'b0, q_ff};
   assign place  = {a_ff[COORD_W-1], a_ff} + offset;

   always_comb begin
      a_in   = a_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      qs_in  = qs_ff;
      rs_in  = rs_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      if (ctl.load_seg) begin
         a_in   = start_coord;
         neg_in = delta[COORD_W];
         mag_in = delta_abs[COORD_W-1:0];
      end
      if (ctl.load_div) begin
         qs_in = quo;
         rs_in = rem;
         q_in  = quo;
         r_in  = rem;
      end else if (ctl.advance) begin
         q_in = q_ff + qs_ff + COORD_W'(wrap);
         r_in = wrap ? r_wrap[DIVR_W-1:0] : r_sum[DIVR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      qs_ff  <= qs_in;
      rs_ff  <= rs_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
   end

   assign mag = mag_ff;
   assign pos = place[COORD_W-1:0];

endmodule

// ----- hdl/polyline_light_spreader_core.sv -----
// Top level of the polyline light spreader: sequencer, registers and result stage.
//
// Each request beat is one segment of a bolt. The block adds num_lights to an
// exact remainder accumulator and divides by segment_count (0 counts as 1);
// the quotient n is the segment's light count, the remainder is kept. The
// lights, capped by the bolt budget MAX_LIGHTS and by 64 per segment, sit at
// start + (end - start) * k / (n + 1) for k = 1..n, truncated toward zero on
// each axis, and leave as response beats with a running index (mod 64) and a
// last-of-segment flag. bolt_start clears the accumulator and the index first.
// All divisions run on one restoring divider that retires one quotient bit a
// cycle: one division for n and one per axis for |delta| / (n + 1). After that
// an incremental quotient and remainder stepper per axis gives one light a
// cycle while the output register can take it. The axis divisions are skipped
// when a segment yields no light. req_ready is high only between segments.
// Responses sit in an output register, so a stalled response beat does not
// stop the next segment from starting its divisions. Configuration beats are
// taken at any time (csr_ready is always high) but are meant for an idle
// block.
`include "polyline_light_spreader_core_macros.svh"

module polyline_light_spreader_core #(
   parameter int MAX_LIGHTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pls_pkg::pls_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pls_pkg::pls_rsp_type                rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pls_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pls_pkg::CSR_DATA_W-1:0]      csr_data
);
   import pls_pkg::*;

   // Lights placed in the current bolt, saturating at MAX_LIGHTS.
   localparam int PW    = $clog2(MAX_LIGHTS + 1);
   localparam int CMP_W = ((PW > SUM_W) ? PW : SUM_W) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_N,
      S_DIV_X,
      S_DIV_Y,
      S_DIV_Z,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic               go_ff, go_in;
   logic [NL_W-1:0]    num_lights_ff, num_lights_in;
   logic [SEG_W-1:0]   seg_count_ff, seg_count_in;
   logic [SEG_W-1:0]   acc_ff, acc_in;
   logic [PW-1:0]      placed_ff, placed_in;
   logic [SUM_W-1:0]   n1_ff, n1_in;
   logic [EMIT_W-1:0]  remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pls_rsp_type        rsp_ff, rsp_in;

   // Shared divider hookup.
   logic [DIVD_W-1:0]  div_dividend;
   logic [DIVR_W-1:0]  div_divisor;
   logic               div_done;
   logic [DIVD_W-1:0]  div_quo;
   logic [DIVR_W-1:0]  div_rem;

   // Axis steppers.
   pls_axis_ctl_type    ctl_x, ctl_y, ctl_z;
   logic [COORD_W-1:0]  mag_x, mag_y, mag_z;
   logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;

   logic [SUM_W-1:0]   budget_sum;
   logic [SUM_W-1:0]   n_div;
   logic [CMP_W-1:0]   room;
   logic [CMP_W-1:0]   n_wide;
   logic [CMP_W-1:0]   cap1;
   logic [CMP_W-1:0]   cap2;
   logic [EMIT_W-1:0]  emit_count;
   logic               out_free;

   // The accumulator stays below segment_count, so the sum never overflows.
   assign budget_sum = {1'b0, acc_ff} + SUM_W'(num_lights_ff);

   // Light count of the segment: n, clipped by the bolt's remaining budget and
   // by the per-segment limit. Only meaningful while the n division finishes.
   assign n_div      = div_quo[SUM_W-1:0];
   assign n_wide     = CMP_W'(n_div);
   assign room       = CMP_W'(MAX_LIGHTS) - CMP_W'(placed_ff);
   assign cap1       = (n_wide < room) ? n_wide : room;
   assign cap2       = (cap1 < CMP_W'(RESULT_LIMIT)) ? cap1 : CMP_W'(RESULT_LIMIT);
   assign emit_count = EMIT_W'(cap2);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      div_dividend = DIVD_W'(budget_sum);
      div_divisor  = (seg_count_ff == '0) ? DIVR_W'(1) : DIVR_W'(seg_count_ff);
      case (state_ff)
         S_DIV_X: begin
            div_dividend = DIVD_W'(mag_x);
            div_divisor  = n1_ff;
         end
         S_DIV_Y: begin
            div_dividend = DIVD_W'(mag_y);
            div_divisor  = n1_ff;
         end
         S_DIV_Z: begin
            div_dividend = DIVD_W'(mag_z);
            div_divisor  = n1_ff;
         end
         default: begin
         end
      endcase
   end

   pls_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   pls_axis u_axis_x (
      .clock       (clock),
      .ctl         (ctl_x),
      .start_coord (req_payload.start_x),
      .end_coord   (req_payload.end_x),
      .quo         (COORD_W'(div_quo)),
      .rem         (div_rem),
      .n1          (n1_ff),
      .mag         (mag_x),
      .pos         (pos_x)
   );

   pls_axis u_axis_y (
      .clock       (clock),
      .ctl         (ctl_y),
      .start_coord (req_payload.start_y),
      .end_coord   (req_payload.end_y),
      .quo         (COORD_W'(div_quo)),
      .rem         (div_rem),
      .n1          (n1_ff),
      .mag         (mag_y),
      .pos         (pos_y)
   );

   pls_axis u_axis_z (
      .clock       (clock),
      .ctl         (ctl_z),
      .start_coord (req_payload.start_z),
      .end_coord   (req_payload.end_z),
      .quo         (COORD_W'(div_quo)),
      .rem         (div_rem),
      .n1          (n1_ff),
      .mag         (mag_z),
      .pos         (pos_z)
   );

   // Sequencer: divide for n, then once per axis, then stream the lights.
   always_comb begin
      state_in      = state_ff;
      go_in         = 1'b0;
      num_lights_in = num_lights_ff;
      seg_count_in  = seg_count_ff;
      acc_in        = acc_ff;
      placed_in     = placed_ff;
      n1_in         = n1_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      ctl_x         = '0;
      ctl_y         = '0;
      ctl_z         = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_LIGHTS:    num_lights_in = csr_data[NL_W-1:0];
            CSR_SEGMENT_COUNT: seg_count_in  = csr_data[SEG_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl_x.load_seg = 1'b1;
               ctl_y.load_seg = 1'b1;
               ctl_z.load_seg = 1'b1;
               if (req_payload.bolt_start) begin
                  acc_in    = '0;
                  placed_in = '0;
               end
               go_in    = 1'b1;
               state_in = S_DIV_N;
            end
         end
         S_DIV_N: begin
            if (div_done) begin
               // The full quotient leaves the accumulator even when the
               // budget clips the number of lights actually placed.
               acc_in    = div_rem[SEG_W-1:0];
               n1_in     = n_div + 1'b1;
               remain_in = emit_count;
               if (emit_count == '0) begin
                  state_in = S_IDLE;
               end else begin
                  go_in    = 1'b1;
                  state_in = S_DIV_X;
               end
            end
         end
         S_DIV_X: begin
            if (div_done) begin
               ctl_x.load_div = 1'b1;
               go_in          = 1'b1;
               state_in       = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (div_done) begin
               ctl_y.load_div = 1'b1;
               go_in          = 1'b1;
               state_in       = S_DIV_Z;
            end
         end
         S_DIV_Z: begin
            if (div_done) begin
               ctl_z.load_div = 1'b1;
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.light_x         = pos_x;
               rsp_in.light_y         = pos_y;
               rsp_in.light_z         = pos_z;
               rsp_in.light_index     = LIDX_W'(placed_ff);
               rsp_in.last_of_segment = (remain_ff == EMIT_W'(1));
               ctl_x.advance          = 1'b1;
               ctl_y.advance          = 1'b1;
               ctl_z.advance          = 1'b1;
               placed_in              = placed_ff + 1'b1;
               remain_in              = remain_ff - 1'b1;
               if (remain_ff == EMIT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         go_ff         <= 1'b0;
         num_lights_ff <= NUM_LIGHTS_RESET;
         seg_count_ff  <= SEG_COUNT_RESET;
         acc_ff        <= '0;
         placed_ff     <= '0;
         remain_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         go_ff         <= go_in;
         num_lights_ff <= num_lights_in;
         seg_count_ff  <= seg_count_in;
         acc_ff        <= acc_in;
         placed_ff     <= placed_in;
         remain_ff     <= remain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n1_ff  <= n1_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A segment is taken only from idle, and the block is busy right after.
   `PLS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // The bolt never places more lights than its budget.
   `PLS_ASSERT_IMP(a_budget_cap, clock, reset, 1'b1, placed_ff <= PW'(MAX_LIGHTS))
   // Streaming only happens with lights left to give.
   `PLS_ASSERT_IMP(a_emit_nonzero, clock, reset, state_ff == S_EMIT, remain_ff != '0)
   // The divider only finishes while the sequencer waits for it.
   `PLS_ASSERT_IMP(a_done_in_div, clock, reset, div_done, state_ff != S_IDLE && state_ff != S_EMIT)

endmodule
